// ===== design/svsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice SysEx decoder package
// Shared types, codes and the packed voice unpacking table for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package svsd_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [12:0] PosMax = 13'd8191;

  localparam logic [1:0] FmtSingle = 2'd0;
  localparam logic [1:0] FmtFramed = 2'd1;
  localparam logic [1:0] FmtRaw    = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadHdr   = 3'd1;
  localparam logic [2:0] StBadType  = 3'd2;
  localparam logic [2:0] StBadLen   = 3'd3;
  localparam logic [2:0] StShort    = 3'd4;
  localparam logic [2:0] StBadCks   = 3'd5;
  localparam logic [2:0] StBadRaw   = 3'd6;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic       is_status;
    logic [4:0] voice_number;
    logic [7:0] param_index;
    logic [7:0] param_value;
    logic [2:0] status_code;
    logic [1:0] source_format;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    AK_NONE,
    AK_DIRECT,
    AK_UNPACK
  } akind_e;

  typedef struct packed {
    akind_e      a_kind;
    logic [11:0] a_addr;
    logic [7:0]  a_byte;
    logic        b_valid;
    logic [7:0]  b_byte;
    logic        st_valid;
    logic [2:0]  st_code;
    logic [1:0]  fmt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] idx;
    logic [7:0] val;
  } unp_t;

  // Maps one packed voice byte to its parameter(s); sel picks which one.
  function automatic unp_t unpack_field(input logic [6:0] ofs, input logic [1:0] sel,
                                        input logic [7:0] p);
    unp_t       r;
    logic [2:0] g;
    logic [6:0] k;
    logic [7:0] base;
    r.cnt = 2'd1;
    r.idx = 8'd0;
    r.val = p;
    if (ofs >= 7'd85) g = 3'd5;
    else if (ofs >= 7'd68) g = 3'd4;
    else if (ofs >= 7'd51) g = 3'd3;
    else if (ofs >= 7'd34) g = 3'd2;
    else if (ofs >= 7'd17) g = 3'd1;
    else g = 3'd0;
    k = ofs - ({g, 4'b0000} + {4'b0000, g});
    base = {1'b0, g, 4'b0000} + {3'b000, g, 2'b00} + {5'b00000, g};
    if (ofs < 7'd102) begin
      case (k)
        7'd11: begin
          r.cnt = 2'd2;
          if (sel == 2'd0) begin
            r.idx = base + 8'd11;
            r.val = {6'b0, p[1:0]};
          end else begin
            r.idx = base + 8'd12;
            r.val = {6'b0, p[3:2]};
          end
        end
        7'd12: begin
          r.cnt = 2'd2;
          if (sel == 2'd0) begin
            r.idx = base + 8'd13;
            r.val = {5'b0, p[2:0]};
          end else begin
            r.idx = base + 8'd20;
            r.val = {4'b0, p[6:3]};
          end
        end
        7'd13: begin
          r.cnt = 2'd2;
          if (sel == 2'd0) begin
            r.idx = base + 8'd14;
            r.val = {6'b0, p[1:0]};
          end else begin
            r.idx = base + 8'd15;
            r.val = {5'b0, p[4:2]};
          end
        end
        7'd14: r.idx = base + 8'd16;
        7'd15: begin
          r.cnt = 2'd2;
          if (sel == 2'd0) begin
            r.idx = base + 8'd17;
            r.val = {7'b0, p[0]};
          end else begin
            r.idx = base + 8'd18;
            r.val = {3'b0, p[5:1]};
          end
        end
        7'd16: r.idx = base + 8'd19;
        default: r.idx = base + {1'b0, k};
      endcase
    end else if (ofs < 7'd110) begin
      r.idx = {1'b0, ofs} + 8'd24;
    end else if (ofs == 7'd110) begin
      r.idx = 8'd134;
      r.val = {3'b0, p[4:0]};
    end else if (ofs == 7'd111) begin
      r.cnt = 2'd2;
      if (sel == 2'd0) begin
        r.idx = 8'd135;
        r.val = {5'b0, p[2:0]};
      end else begin
        r.idx = 8'd136;
        r.val = {7'b0, p[3]};
      end
    end else if (ofs < 7'd116) begin
      r.idx = {1'b0, ofs} + 8'd25;
    end else if (ofs == 7'd116) begin
      r.cnt = 2'd3;
      if (sel == 2'd0) begin
        r.idx = 8'd141;
        r.val = {7'b0, p[0]};
      end else if (sel == 2'd1) begin
        r.idx = 8'd142;
        r.val = {5'b0, p[3:1]};
      end else begin
        r.idx = 8'd143;
        r.val = {5'b0, p[6:4]};
      end
    end else if (ofs == 7'd117) begin
      r.idx = 8'd144;
    end else begin
      r.idx = {1'b0, ofs} + 8'd27;
      if (ofs == 7'd127) begin
        r.cnt = 2'd2;
        if (sel != 2'd0) begin
          r.idx = 8'd155;
          r.val = 8'h3F;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/synth_voice_sysex_decoder.sv =====
// ----------------------------------------------------------------------------
// FM voice SysEx decoder
// A byte's command is registered in the command queue and then in the back
// end's output register; a byte gives up to four results, one per cycle
// while the result port is empty or popped.
// Throughput: one byte per cycle into the command queue while it is not full;
// the queue lets new bytes in while earlier results still wait to be popped.
// Reset clears the stream state and the format register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module synth_voice_sysex_decoder #(
  parameter int unsigned QueueDepth = svsd_pkg::QueueDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 push,
  output logic                      full,
  input  wire svsd_pkg::in_item_t   in_item_i,
  output logic                      empty,
  input  wire logic                 pop,
  output svsd_pkg::out_item_t       out_item_o
);
  import svsd_pkg::*;

  cmd_t cmd, q_data;
  logic cmd_valid, q_valid, q_rd, accept;

  assign accept = push && !full;

  svsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  svsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .valid_o   (q_valid)
  );

  svsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== design/svsd_front.sv =====
// ----------------------------------------------------------------------------
// Voice SysEx decoder front end
// Tracks the byte position, checks the header and checksum, detects the dump
// format and turns each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svsd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              accept_i,
  input  wire svsd_pkg::in_item_t in_item_i,
  output svsd_pkg::cmd_t          cmd_o,
  output logic                    cmd_valid_o
);
  import svsd_pkg::*;

  logic [12:0] pos_q, pos_d, pos_inc;
  logic [1:0]  fmt_q, fmt_d, fmt_cur;
  logic [6:0]  cks_q, cks_d, cks_sum;
  logic [7:0]  held_q, held_d;
  logic [2:0]  err_q, err_d, cand, code;
  logic        raw_q, raw_d;
  logic        fsel_q;
  logic [7:0]  b;
  cmd_t        cmd;

  assign b = in_item_i.byte_in;

  always_comb begin
    fmt_cur = (pos_q == 13'd0) ? {1'b0, fsel_q} : fmt_q;
    fmt_d   = fmt_cur;
    cks_d   = cks_q;
    held_d  = held_q;
    raw_d   = raw_q;
    cand    = StOk;
    cks_sum = cks_q + b[6:0];
    cmd          = '0;
    cmd.a_kind   = AK_NONE;
    if (fmt_cur == FmtSingle) begin
      if (pos_q == 13'd0 && b != 8'hF0) begin
        cand = StBadHdr;
      end else if (pos_q == 13'd1 && b != 8'h43) begin
        cand = StBadHdr;
      end else if (pos_q == 13'd3 && b != 8'h00) begin
        cand = StBadType;
      end else if (pos_q == 13'd4) begin
        held_d = b;
      end else if (pos_q == 13'd5) begin
        if (({held_q, 7'b0} | {7'b0, b}) != 15'd155) cand = StBadLen;
      end else if (pos_q >= 13'd6 && pos_q < 13'd161) begin
        cks_d      = cks_sum;
        cmd.a_kind = AK_DIRECT;
        cmd.a_addr = {4'b0, 8'(pos_q - 13'd6)};
        cmd.a_byte = b;
      end else if (pos_q == 13'd161) begin
        cks_d      = cks_sum;
        if (cks_sum != 7'd0) cand = StBadCks;
        cmd.a_kind = AK_DIRECT;
        cmd.a_addr = 12'd155;
        cmd.a_byte = 8'h3F;
      end
    end else if (pos_q == 13'd0) begin
      if (b == 8'hF0) begin
        held_d = b;
      end else begin
        fmt_d      = FmtRaw;
        cmd.a_kind = AK_UNPACK;
        cmd.a_addr = 12'd0;
        cmd.a_byte = b;
      end
    end else if (pos_q == 13'd1 && fmt_cur == FmtFramed) begin
      if (b != 8'h43) begin
        fmt_d       = FmtRaw;
        cmd.a_kind  = AK_UNPACK;
        cmd.a_addr  = 12'd0;
        cmd.a_byte  = held_q;
        cmd.b_valid = 1'b1;
        cmd.b_byte  = b;
      end
    end else if (fmt_cur == FmtFramed) begin
      if (pos_q == 13'd3 && b != 8'h09) begin
        cand = StBadType;
      end else if (pos_q >= 13'd6 && pos_q < 13'd4102) begin
        cks_d      = cks_sum;
        cmd.a_kind = AK_UNPACK;
        cmd.a_addr = 12'(pos_q - 13'd6);
        cmd.a_byte = b;
      end else if (pos_q == 13'd4102) begin
        cks_d = cks_sum;
        if (cks_sum != 7'd0) cand = StBadCks;
      end
    end else begin
      if (pos_q < 13'd4096) begin
        cmd.a_kind = AK_UNPACK;
        cmd.a_addr = pos_q[11:0];
        cmd.a_byte = b;
      end else if (pos_q == 13'd4096) begin
        raw_d = (b == 8'hF7);
      end
    end

    err_d   = (err_q != StOk) ? err_q : cand;
    pos_inc = (pos_q == PosMax) ? pos_q : pos_q + 13'd1;

    code = err_d;
    if (code == StOk) begin
      case (fmt_d)
        FmtSingle: if (pos_inc < 13'd162) code = StShort;
        FmtFramed: if (pos_inc < 13'd4104) code = StShort;
        default: begin
          if (!(pos_inc == 13'd4096 || (pos_inc == 13'd4097 && raw_d))) code = StBadRaw;
        end
      endcase
    end
    cmd.fmt = fmt_d;
    pos_d   = pos_inc;

    if (in_item_i.end_of_message) begin
      cmd.st_valid = 1'b1;
      cmd.st_code  = code;
      pos_d  = 13'd0;
      fmt_d  = FmtSingle;
      cks_d  = 7'd0;
      held_d = 8'd0;
      err_d  = StOk;
      raw_d  = 1'b0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.a_kind != AK_NONE || cmd.st_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 13'd0;
      fmt_q  <= FmtSingle;
      cks_q  <= 7'd0;
      held_q <= 8'd0;
      err_q  <= StOk;
      raw_q  <= 1'b0;
      fsel_q <= 1'b0;
    end else begin
      if (cfg_we_i) fsel_q <= cfg_wdata_i;
      if (accept_i) begin
        pos_q  <= pos_d;
        fmt_q  <= fmt_d;
        cks_q  <= cks_d;
        held_q <= held_d;
        err_q  <= err_d;
        raw_q  <= raw_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_clean_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == 13'd0 |-> (err_q == StOk && cks_q == 7'd0 && !raw_q))
    else $error("Stream state not clear at message start.");
`endif

endmodule

`default_nettype wire

// ===== design/svsd_queue.sv =====
// ----------------------------------------------------------------------------
// Voice SysEx decoder command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svsd_queue #(
  parameter int unsigned Depth = svsd_pkg::QueueDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire svsd_pkg::cmd_t wr_data_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output svsd_pkg::cmd_t      rd_data_o,
  output logic                valid_o
);
  import svsd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) count_q <= count_q + 1'b1;
      else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> rd_ptr_q == wr_ptr_q)
    else $error("Queue pointers differ while the queue is empty.");
`endif

endmodule

`default_nettype wire

// ===== design/svsd_back.sv =====
// ----------------------------------------------------------------------------
// Voice SysEx decoder back end
// Expands each command into its parameter and status results, into an output
// register, one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module svsd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire svsd_pkg::cmd_t q_data_i,
  output logic                q_rd_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output svsd_pkg::out_item_t out_item_o
);
  import svsd_pkg::*;

  logic [1:0] step_q, step_d;
  logic       out_valid_q;
  out_item_t  out_q, res;
  unp_t       ua, ub;
  logic [1:0] n_a;
  logic [2:0] total;
  logic       last, advance;

  always_comb begin
    ua = unpack_field(q_data_i.a_addr[6:0], step_q, q_data_i.a_byte);
    ub = unpack_field(7'd1, 2'd0, q_data_i.b_byte);
    case (q_data_i.a_kind)
      AK_UNPACK: n_a = ua.cnt;
      AK_DIRECT: n_a = 2'd1;
      default:   n_a = 2'd0;
    endcase
    total = {1'b0, n_a} + {2'b0, q_data_i.b_valid} + {2'b0, q_data_i.st_valid};
    last  = ({1'b0, step_q} + 3'd1) == total;

    res               = '0;
    res.source_format = q_data_i.fmt;
    res.last_of_run   = last;
    if (step_q < n_a) begin
      if (q_data_i.a_kind == AK_UNPACK) begin
        res.voice_number = q_data_i.a_addr[11:7];
        res.param_index  = ua.idx;
        res.param_value  = ua.val;
      end else begin
        res.param_index  = q_data_i.a_addr[7:0];
        res.param_value  = q_data_i.a_byte;
      end
    end else if (q_data_i.b_valid && step_q == n_a) begin
      res.param_index = ub.idx;
      res.param_value = ub.val;
    end else begin
      res.is_status   = 1'b1;
      res.status_code = q_data_i.st_code;
    end
  end

  assign advance = q_valid_i && (!out_valid_q || pop_i);
  assign q_rd_o  = advance && last;
  assign step_d  = last ? 2'd0 : step_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_step_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != 2'd0 |-> q_valid_i)
    else $error("Partly expanded command left the queue.");
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> {1'b0, step_q} < total)
    else $error("Result step runs past the command's result count.");
`endif

endmodule

`default_nettype wire
